// File: rtl/bounded_deque_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque
// Clocked assertion helpers; every check is gated off while reset is active.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_TOP_ASSERT_SVH
`define BOUNDED_DEQUE_TOP_ASSERT_SVH

// Property sampled on the rising clock edge, disabled during reset.
`define BDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true on a rising clock edge.
`define BDQ_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, codes and payload types of the bounded deque.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int unsigned DEPTH = 8;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OCC_W = 4;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    req_type_e          req_type;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] pop_value;
    status_e            status;
    logic [OCC_W-1:0]   occupancy;
  } rsp_t;

  // per-cell load controls; at most one is set in a cycle
  typedef struct packed {
    logic take_left;   // shift toward the rear (push front)
    logic take_right;  // shift toward the front (pop front)
    logic load;        // write the pushed word (push rear)
  } cell_ctl_t;

endpackage

// File: rtl/bdq_cell.sv
// ----------------------------------------------------------------------------
// bdq_cell
// One storage cell of the deque chain: holds a word, loads from a neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdq_cell (
  input  logic                  clk_i,
  input  bdq_pkg::cell_ctl_t    ctl_i,
  input  logic signed [31:0]    left_i,
  input  logic signed [31:0]    right_i,
  input  logic signed [31:0]    push_i,
  output logic signed [31:0]    data_o
);

  logic signed [31:0] data_q;

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    priority if (ctl_i.take_left) begin
      data_q <= left_i;
    end else if (ctl_i.take_right) begin
      data_q <= right_i;
    end else if (ctl_i.load) begin
      data_q <= push_i;
    end else begin
      data_q <= data_q;
    end
  end

  assign data_o = data_q;

endmodule

// File: rtl/bounded_deque_top.sv
// ----------------------------------------------------------------------------
// bounded_deque_top
// Bounded double-ended queue of signed 32-bit words built as a chain of cells.
// ----------------------------------------------------------------------------
//
// Channel   Ports                          Dir  Handshake
// request   start_i, busy_o, req_i         in   taken when start_i && !busy_o
// response  rsp_valid_o, rsp_o             out  one-cycle strobe, no stall
//
// Cycles: one request per clock; the response shows in the cycle after the
//   request is taken, from the response register.
// busy_o stays low: the chain and the count update at the edge that takes the
//   request, so a new request may follow on every clock.
// Reset: rst_ni clears the fill count and the response strobe; cell contents
//   are left as they are and are never read before a push writes them.
// Stalls: the receiver cannot hold responses off; each strobe is one cycle.
//
// Cell 0 is always the front word, cell (count-1) the rear word. Push front
// shifts the whole chain toward the rear, pop front shifts it toward the
// front, push rear loads the cell at index count, pop rear only reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bounded_deque_top_assert.svh"

module bounded_deque_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  bdq_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output bdq_pkg::rsp_t rsp_o
);

  localparam int unsigned DEPTH = bdq_pkg::DEPTH;
  localparam int unsigned IDX_W = bdq_pkg::IDX_W;
  localparam int unsigned CNT_W = bdq_pkg::CNT_W;

  logic                  accept;
  logic                  is_push;
  logic                  is_front;
  logic                  full;
  logic                  empty;
  logic                  ok_push;
  logic                  ok_pop;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      cnt_m1;
  logic signed [31:0]    cell_data [DEPTH];
  bdq_pkg::cell_ctl_t    cell_ctl  [DEPTH];
  logic                  rsp_valid_q;
  bdq_pkg::rsp_t         rsp_q, rsp_d;

  // never stalls: every request finishes in the cycle it is taken
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign is_push  = (req_i.req_type == bdq_pkg::REQ_PUSH_FRONT) ||
                    (req_i.req_type == bdq_pkg::REQ_PUSH_REAR);
  assign is_front = (req_i.req_type == bdq_pkg::REQ_PUSH_FRONT) ||
                    (req_i.req_type == bdq_pkg::REQ_POP_FRONT);
  assign full     = (cnt_q == CNT_W'(DEPTH));
  assign empty    = (cnt_q == '0);
  assign ok_push  = accept && is_push && !full;
  assign ok_pop   = accept && !is_push && !empty;
  assign cnt_m1   = cnt_q - CNT_W'(1);

  // occupancy count
  always_comb begin
    priority if (ok_push) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (ok_pop) begin
      cnt_d = cnt_m1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_w;
    logic signed [31:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = req_i.push_value;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    assign cell_ctl[i].take_left  = ok_push && is_front;
    assign cell_ctl[i].take_right = ok_pop && is_front;
    assign cell_ctl[i].load       = ok_push && !is_front && (cnt_q == CNT_W'(i));

    bdq_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl[i]),
      .left_i  (left_w),
      .right_i (right_w),
      .push_i  (req_i.push_value),
      .data_o  (cell_data[i])
    );
  end

  // response
  always_comb begin
    rsp_d.occupancy = bdq_pkg::OCC_W'(cnt_d);
    rsp_d.pop_value = '0;
    rsp_d.status    = bdq_pkg::ST_DONE;
    priority if (is_push && full) begin
      rsp_d.status = bdq_pkg::ST_FULL;
    end else if (!is_push && empty) begin
      rsp_d.status = bdq_pkg::ST_EMPTY;
    end else if (is_push) begin
      // push taken: no word returned
      rsp_d.pop_value = '0;
    end else begin
      rsp_d.pop_value = is_front ? cell_data[0] : cell_data[cnt_m1[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      rsp_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // assertions
  `BDQ_ASSERT(a_rsp_after_req, accept |=> rsp_valid_o, "response missing after request")
  `BDQ_ASSERT(a_no_extra_rsp, !accept |=> !rsp_valid_o, "response without request")
  `BDQ_ASSERT_NEVER(a_cnt_range, cnt_q > CNT_W'(DEPTH), "fill count beyond depth")
  `BDQ_ASSERT(a_refused_keeps_cnt, rsp_valid_o && (rsp_o.status != bdq_pkg::ST_DONE) |-> $stable(cnt_q), "refused request changed the count")
  `BDQ_ASSERT(a_refused_zero_pop, rsp_valid_o && (rsp_o.status != bdq_pkg::ST_DONE) |-> (rsp_o.pop_value == '0), "refused request returned a word")

endmodule

// File: tb/bounded_deque_top_tb.sv
// ----------------------------------------------------------------------------
// bounded_deque_top_tb
// Self-checking bench for the bounded deque. A directed pass covers empty
// and full refusals, extreme words and pointer wrap. A random pass follows,
// with push/pop mix drifting per segment so the queue swings between empty
// and full. Each response is checked against an in-bench deque model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_deque_top_tb;

  localparam int unsigned CYCLE_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned RANDOM_ITEMS = 400;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start_i = 1'b0;
  bdq_pkg::req_t  req_i = '0;
  logic           busy_o;
  logic           rsp_valid_o;
  bdq_pkg::rsp_t  rsp_o;

  bounded_deque_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  bdq_pkg::req_t  pending_reqs[$];   // requests waiting to be driven
  bdq_pkg::rsp_t  expected_rsps[$];  // predicted responses, oldest first
  int    issued_cnt = 0;
  int    error_cnt = 0;
  int    cycle_cnt = 0;

  // Deque model: circular store, head position, word count.
  logic [31:0] model_words[bdq_pkg::DEPTH];
  int          model_head = 0;
  int          model_fill = 0;

  // --------------------------------------------------------------------------
  // Deque model: apply one request, return the response it should produce.
  // --------------------------------------------------------------------------
  function automatic bdq_pkg::rsp_t deque_apply(bdq_pkg::req_t r);
    bdq_pkg::rsp_t res;
    int   pos;
    res.pop_value = '0;
    res.status    = bdq_pkg::ST_DONE;
    case (r.req_type)
      bdq_pkg::REQ_PUSH_FRONT: begin
        if (model_fill >= bdq_pkg::DEPTH) begin
          res.status = bdq_pkg::ST_FULL;
        end else begin
          model_head = (model_head == 0) ? bdq_pkg::DEPTH - 1 : model_head - 1;
          model_words[model_head] = r.push_value;
          model_fill++;
        end
      end
      bdq_pkg::REQ_PUSH_REAR: begin
        if (model_fill >= bdq_pkg::DEPTH) begin
          res.status = bdq_pkg::ST_FULL;
        end else begin
          pos = (model_head + model_fill) % bdq_pkg::DEPTH;
          model_words[pos] = r.push_value;
          model_fill++;
        end
      end
      bdq_pkg::REQ_POP_FRONT: begin
        if (model_fill == 0) begin
          res.status = bdq_pkg::ST_EMPTY;
        end else begin
          res.pop_value = model_words[model_head];
          model_head = (model_head + 1) % bdq_pkg::DEPTH;
          model_fill--;
        end
      end
      default: begin  // pop rear
        if (model_fill == 0) begin
          res.status = bdq_pkg::ST_EMPTY;
        end else begin
          pos = (model_head + model_fill - 1) % bdq_pkg::DEPTH;
          res.pop_value = model_words[pos];
          model_fill--;
        end
      end
    endcase
    res.occupancy = bdq_pkg::OCC_W'(model_fill);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present the next pending request once the current one is taken.
  // Idles ~12% of cycles, except for a quiet stretch in the random pass.
  // --------------------------------------------------------------------------
  function automatic bit driver_idles();
    if (issued_cnt >= 150 && issued_cnt < 250) begin
      return 1'b0;
    end
    return ($urandom_range(99) < 12);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || !busy_o) begin
      if (pending_reqs.size() > 0 && !driver_idles()) begin
        start_i <= 1'b1;
        req_i   <= pending_reqs.pop_front();
        issued_cnt++;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  task automatic check_response(bdq_pkg::rsp_t exp_rsp, bdq_pkg::rsp_t got);
    if (got.pop_value !== exp_rsp.pop_value) begin
      $display("%0t: pop_value mismatch: expected %0h, actual %0h",
               $time, exp_rsp.pop_value, got.pop_value);
      error_cnt++;
    end
    if (got.status !== exp_rsp.status) begin
      $display("%0t: status mismatch: expected %0d, actual %0d",
               $time, exp_rsp.status, got.status);
      error_cnt++;
    end
    if (got.occupancy !== exp_rsp.occupancy) begin
      $display("%0t: occupancy mismatch: expected %0d, actual %0d",
               $time, exp_rsp.occupancy, got.occupancy);
      error_cnt++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: check each response strobe against the oldest prediction, then
  // predict for a request taken on this edge. Old values are sampled here
  // since all drives use nonblocking assignments.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_o) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response: got %p", $time, rsp_o);
          error_cnt++;
        end else begin
          check_response(expected_rsps.pop_front(), rsp_o);
        end
      end
      if (start_i && !busy_o) begin
        expected_rsps.push_back(deque_apply(req_i));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_req(bdq_pkg::req_type_e op, logic [31:0] value);
    bdq_pkg::req_t r;
    r.req_type   = op;
    r.push_value = value;
    pending_reqs.push_back(r);
  endtask

  // Mostly random words, with the odd extreme or zero thrown in.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // push_pct sets how often a push is picked; front/rear split is even.
  function automatic bdq_pkg::req_type_e pick_op(int unsigned push_pct);
    bit is_push;
    bit at_front;
    is_push  = ($urandom_range(99) < push_pct);
    at_front = $urandom_range(1);
    if (is_push) begin
      return at_front ? bdq_pkg::REQ_PUSH_FRONT : bdq_pkg::REQ_PUSH_REAR;
    end
    return at_front ? bdq_pkg::REQ_POP_FRONT : bdq_pkg::REQ_POP_REAR;
  endfunction

  // --------------------------------------------------------------------------
  // Timeout
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned push_pct;
    int unsigned seg_len;
    int          made;

    // Directed: refusals on an empty queue (push_value must be ignored)
    queue_req(bdq_pkg::REQ_POP_FRONT, 32'hDEAD_BEEF);
    queue_req(bdq_pkg::REQ_POP_REAR,  32'h1234_5678);
    // Fill with extremes from both ends; head wraps below zero at once
    queue_req(bdq_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
    queue_req(bdq_pkg::REQ_PUSH_REAR,  32'h7FFF_FFFF);
    queue_req(bdq_pkg::REQ_PUSH_FRONT, 32'h0000_0000);
    queue_req(bdq_pkg::REQ_PUSH_REAR,  32'hFFFF_FFFF);
    queue_req(bdq_pkg::REQ_PUSH_FRONT, 32'h5555_5555);
    queue_req(bdq_pkg::REQ_PUSH_REAR,  32'hAAAA_AAAA);
    queue_req(bdq_pkg::REQ_PUSH_FRONT, 32'h0000_0001);
    queue_req(bdq_pkg::REQ_PUSH_REAR,  32'hFFFF_FFFE);
    // Full: both pushes refused
    queue_req(bdq_pkg::REQ_PUSH_FRONT, 32'h0F0F_0F0F);
    queue_req(bdq_pkg::REQ_PUSH_REAR,  32'hF0F0_F0F0);
    // Drain alternating ends down to empty; a stored zero pops normally
    for (int i = 0; i < bdq_pkg::DEPTH; i++) begin
      queue_req((i % 2) ? bdq_pkg::REQ_POP_REAR : bdq_pkg::REQ_POP_FRONT, $urandom);
    end
    // Empty again with head back at zero; then single-word turnarounds
    queue_req(bdq_pkg::REQ_POP_FRONT,  $urandom);
    queue_req(bdq_pkg::REQ_PUSH_REAR,  32'h0000_0000);
    queue_req(bdq_pkg::REQ_POP_FRONT,  $urandom);
    queue_req(bdq_pkg::REQ_PUSH_FRONT, 32'h8000_0001);
    queue_req(bdq_pkg::REQ_POP_REAR,   $urandom);

    // Random: segments with a drifting push bias so the queue keeps hitting
    // both the full and the empty limit.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      case ($urandom_range(3))
        0:       push_pct = 15;
        1:       push_pct = 85;
        default: push_pct = 50;
      endcase
      seg_len = $urandom_range(10, 40);
      for (int i = 0; i < seg_len && made < RANDOM_ITEMS; i++) begin
        queue_req(pick_op(push_pct), pick_word());
        made++;
      end
    end

    // Hold reset, then release it on a rising edge
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Run until every request is taken and answered, then let the pipe settle
    while (pending_reqs.size() > 0 || start_i || expected_rsps.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_cnt == 0 && expected_rsps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/bdq_pkg.sv
rtl/bdq_cell.sv
rtl/bounded_deque_top.sv
tb/bounded_deque_top_tb.sv
